// ===== src/multichannel_symmetric_decimating_fir_core_defines.svh =====
// Assertion macros shared by the filter RTL.
`ifndef MULTICHANNEL_SYMMETRIC_DECIMATING_FIR_CORE_DEFINES_SVH
`define MULTICHANNEL_SYMMETRIC_DECIMATING_FIR_CORE_DEFINES_SVH

// Same-cycle implication, checked on i_clk, held off during reset.
`define MSDF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk, held off during reset.
`define MSDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/msdf_pkg.sv =====
package msdf_pkg;

    localparam int CHANNELS    = 6;
    localparam int HALF_TAPS   = 8;
    localparam int TAPS        = 2 * HALF_TAPS;
    localparam int HIST_FRAMES = TAPS - 1;
    localparam int DECIMATION  = 4;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int ACC_W     = 32;
    localparam int CH_W      = 3;
    localparam int CFG_IDX_W = 4;
    localparam int ROW_W     = CHANNELS * SAMPLE_W;

    localparam int SLOT_W     = (HIST_FRAMES > 1) ? $clog2(HIST_FRAMES) : 1;
    localparam int K_W        = $clog2(TAPS);
    localparam int COEF_IDX_W = (HALF_TAPS > 1) ? $clog2(HALF_TAPS) : 1;
    localparam int PHASE_W    = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam int DRN_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef logic [ROW_W-1:0] t_row;
    typedef logic [ACC_W-1:0] t_acc;

    // Taps k and TAPS-1-k share one weight.
    function automatic logic [COEF_IDX_W-1:0] tap_coef_idx(input logic [K_W-1:0] k);
        logic [K_W-1:0] m;
        m = (k < K_W'(HALF_TAPS)) ? k : K_W'(TAPS - 1) - k;
        return m[COEF_IDX_W-1:0];
    endfunction

endpackage

// ===== src/multichannel_symmetric_decimating_fir_core.sv =====
// Operation: a frame that yields no output is written straight into the history ring; an output
//   frame is taken, its 16 taps are read one history row per cycle, and its results are drained.
// Flow: an output frame holds the input off while its taps are read, set by the single read
//   port of the history memory; results then leave one beat per cycle while m_axis_tready is high.
// Reset: coefficients and decimation phase clear to zero, history rows are marked empty and
//   read as zero until written; memory contents themselves are not cleared.
`include "multichannel_symmetric_decimating_fir_core_defines.svh"

module multichannel_symmetric_decimating_fir_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input frames
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: sample_ch0 [15:0], sample_ch1 .. sample_ch5 [95:80]
    input  logic [msdf_pkg::ROW_W-1:0]          s_axis_tdata,
    // Filtered results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: filtered [15:0]
    output logic [msdf_pkg::SAMPLE_W-1:0]       m_axis_tdata,
    // tuser: channel [2:0]
    output logic [msdf_pkg::CH_W-1:0]           m_axis_tuser,
    output logic                                m_axis_tlast,
    // Coefficient writes
    input  logic                                i_cfg_we,
    input  logic [msdf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [msdf_pkg::COEF_W-1:0]         i_cfg_data
);

    localparam int SUM_W = msdf_pkg::K_W + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    // Sequencer and bookkeeping
    logic [1:0]                           r_state;
    logic [msdf_pkg::COEF_W-1:0]          r_coef [msdf_pkg::HALF_TAPS];
    logic [msdf_pkg::HIST_FRAMES-1:0]     r_row_vld;
    logic [msdf_pkg::SLOT_W-1:0]          r_wp;
    logic [msdf_pkg::PHASE_W-1:0]         r_phase;
    logic [msdf_pkg::K_W-1:0]             r_k;

    // History ring: one row holds one whole frame
    msdf_pkg::t_row                       r_hist [msdf_pkg::HIST_FRAMES];
    msdf_pkg::t_row                       r_rd_data;
    logic                                 r_rd_vld;

    // MAC pipeline
    msdf_pkg::t_row                       r_cur;
    logic                                 r_b_valid;
    logic [msdf_pkg::K_W-1:0]             r_b_k;
    msdf_pkg::t_acc                       r_prod [msdf_pkg::CHANNELS];
    logic                                 r_c_valid;
    msdf_pkg::t_acc                       r_acc  [msdf_pkg::CHANNELS];

    // Result drain and output register
    logic                                 r_drn_busy;
    logic [msdf_pkg::DRN_W-1:0]           r_drn;
    logic                                 r_out_valid;
    logic [msdf_pkg::SAMPLE_W-1:0]        r_out_data;
    logic [msdf_pkg::CH_W-1:0]            r_out_ch;
    logic                                 r_out_last;

    logic                                 w_in_acc;
    logic                                 w_phase0;
    logic                                 w_done;
    logic                                 w_issue;
    logic                                 w_out_load;
    logic                                 w_mem_we;
    msdf_pkg::t_row                       w_mem_wd;
    logic [SUM_W-1:0]                     w_wp_ext;
    logic [SUM_W-1:0]                     w_k_ext;
    logic [SUM_W-1:0]                     w_slot_ext;
    logic [msdf_pkg::SLOT_W-1:0]          w_rd_slot;
    msdf_pkg::t_row                       w_row;
    logic [msdf_pkg::COEF_W-1:0]          w_coef_sel;
    logic [msdf_pkg::SLOT_W-1:0]          w_wp_nxt;
    logic [msdf_pkg::PHASE_W-1:0]         w_phase_nxt;

    // Hold the input off while a burst runs, and hold a new output frame until the
    // previous burst has fully left the accumulators.
    assign w_phase0      = (r_phase == '0);
    assign s_axis_tready = (r_state == S_IDLE) && !(w_phase0 && r_drn_busy);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_issue       = (r_state == S_RUN);
    // Write back once the last product has reached the accumulators
    assign w_done        = (r_state == S_FLUSH) && !r_b_valid && !r_c_valid;

    // Frames without output go straight into the ring; an output frame is written only
    // after its oldest tap (the row it overwrites) has been read.
    assign w_mem_we = (w_in_acc && !w_phase0) || w_done;
    assign w_mem_wd = w_done ? r_cur : s_axis_tdata;

    assign w_wp_nxt    = (r_wp == msdf_pkg::SLOT_W'(msdf_pkg::HIST_FRAMES - 1)) ?
                         '0 : r_wp + 1'b1;
    assign w_phase_nxt = (r_phase == msdf_pkg::PHASE_W'(msdf_pkg::DECIMATION - 1)) ?
                         '0 : r_phase + 1'b1;

    // Sample k frames back lives k slots behind the write pointer, modulo the ring depth
    assign w_wp_ext   = SUM_W'(r_wp);
    assign w_k_ext    = SUM_W'(r_k);
    assign w_slot_ext = (w_wp_ext >= w_k_ext) ? w_wp_ext - w_k_ext :
                        w_wp_ext + SUM_W'(msdf_pkg::HIST_FRAMES) - w_k_ext;
    assign w_rd_slot  = w_slot_ext[msdf_pkg::SLOT_W-1:0];

    // Tap zero is the current frame; an empty row reads as zero
    assign w_row      = (r_b_k == '0) ? r_cur : (r_rd_vld ? r_rd_data : '0);
    assign w_coef_sel = r_coef[msdf_pkg::tap_coef_idx(r_b_k)];

    assign w_out_load = r_drn_busy && (!r_out_valid || m_axis_tready);

    // History memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_hist[r_wp] <= w_mem_wd;
        end
        r_rd_data <= r_hist[w_rd_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_vld   <= '0;
            r_wp        <= '0;
            r_phase     <= '0;
            r_k         <= '0;
            r_rd_vld    <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_drn_busy  <= 1'b0;
            r_drn       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < msdf_pkg::HALF_TAPS; i++) begin
                r_coef[i] <= '0;
            end
        end else begin
            // Writes to indexes beyond the coefficient list are dropped
            if (i_cfg_we && (i_cfg_idx < msdf_pkg::CFG_IDX_W'(msdf_pkg::HALF_TAPS))) begin
                r_coef[i_cfg_idx[msdf_pkg::COEF_IDX_W-1:0]] <= i_cfg_data;
            end

            r_rd_vld  <= r_row_vld[w_rd_slot];
            r_b_valid <= w_issue;
            r_c_valid <= r_b_valid;

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_phase0) begin
                            r_state <= S_RUN;
                            r_k     <= '0;
                        end else begin
                            r_row_vld[r_wp] <= 1'b1;
                            r_wp            <= w_wp_nxt;
                            r_phase         <= w_phase_nxt;
                        end
                    end
                end
                S_RUN: begin
                    if (r_k == msdf_pkg::K_W'(msdf_pkg::TAPS - 1)) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_FLUSH: begin
                    if (w_done) begin
                        r_state         <= S_IDLE;
                        r_row_vld[r_wp] <= 1'b1;
                        r_wp            <= w_wp_nxt;
                        r_phase         <= w_phase_nxt;
                        r_drn_busy      <= 1'b1;
                        r_drn           <= '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Advance the drain one channel per beat through the output register
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                if (r_drn == msdf_pkg::DRN_W'(msdf_pkg::CHANNELS - 1)) begin
                    r_drn_busy <= 1'b0;
                end else begin
                    r_drn <= r_drn + 1'b1;
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_phase0) begin
            r_cur <= s_axis_tdata;
            for (int l = 0; l < msdf_pkg::CHANNELS; l++) begin
                r_acc[l] <= '0;
            end
        end else if (r_c_valid) begin
            for (int l = 0; l < msdf_pkg::CHANNELS; l++) begin
                r_acc[l] <= r_acc[l] + r_prod[l];
            end
        end

        r_b_k <= r_k;
        // One multiplier per channel lane; each tap is multiplied on its own, with the weight its pair shares
        for (int l = 0; l < msdf_pkg::CHANNELS; l++) begin
            r_prod[l] <= msdf_pkg::ACC_W'(w_coef_sel) *
                         msdf_pkg::ACC_W'(w_row[l*msdf_pkg::SAMPLE_W +: msdf_pkg::SAMPLE_W]);
        end

        if (w_out_load) begin
            r_out_data <= r_acc[r_drn][msdf_pkg::ACC_W-1 -: msdf_pkg::SAMPLE_W];
            r_out_ch   <= msdf_pkg::CH_W'(r_drn);
            r_out_last <= (r_drn == msdf_pkg::DRN_W'(msdf_pkg::CHANNELS - 1));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_ch;
    assign m_axis_tlast  = r_out_last;

    `MSDF_ASSERT_SAME(a_last_on_final_ch, m_axis_tvalid && m_axis_tlast, m_axis_tuser == msdf_pkg::CH_W'(msdf_pkg::CHANNELS - 1), "last beat on wrong channel")
    `MSDF_ASSERT_SAME(a_no_mac_in_drain, r_drn_busy, !r_c_valid && !r_b_valid, "accumulators change while draining")
    `MSDF_ASSERT_NEXT(a_done_starts_drain, w_done, r_drn_busy && (r_state == S_IDLE), "write-back did not start the drain")
    `MSDF_ASSERT_SAME(a_wp_in_ring, 1'b1, r_wp <= msdf_pkg::SLOT_W'(msdf_pkg::HIST_FRAMES - 1), "write pointer left the ring")

endmodule
